// ----- hdl/ttab_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timer table package
// Shared types, codes and constants of the timer table engine.
// ----------------------------------------------------------------------------
package ttab_pkg;

  localparam int DEF_SLOTS     = 16;
  localparam int DEF_TIME_BITS = 48;

  localparam int OP_W       = 2;
  localparam int KIND_W     = 3;
  localparam int IN_DATA_W  = 96;
  localparam int OUT_DATA_W = 56;

  localparam logic [31:0] SOON_MAX   = 32'h7FFF_FFFF;
  localparam logic [31:0] SOON_EMPTY = 32'hFFFF_FFFF;
  localparam logic [7:0]  CNT_MAX    = 8'd255;

  typedef enum logic [1:0] {
    OP_ADD,
    OP_SOONEST,
    OP_APPLY,
    OP_CLEAR
  } ttab_op_t;

  typedef enum logic [2:0] {
    KIND_ADD_ACK,
    KIND_SOONEST,
    KIND_FIRING,
    KIND_DONE,
    KIND_CLEARED
  } ttab_kind_t;

  typedef enum logic [1:0] {
    STAT_OK,
    STAT_FULL,
    STAT_ZERO_PERIOD
  } ttab_status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_READ,
    S_CHECK,
    S_MIN,
    S_DIV,
    S_BASE,
    S_WB,
    S_NEXT,
    S_SEND
  } ttab_state_t;

  // Write and valid-bit controls of the slot store.
  typedef struct packed {
    logic wr_all;
    logic wr_exp;
    logic set_valid;
    logic clr_valid;
    logic clr_all;
  } ttab_store_ctl_t;

endpackage

// ----- hdl/ttab_store.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timer slot store
// Per-slot fields in memories with a registered read port, plus valid bits.
// ----------------------------------------------------------------------------
module ttab_store #(
  parameter int TIMER_SLOTS = ttab_pkg::DEF_SLOTS,
  parameter int TIME_BITS   = ttab_pkg::DEF_TIME_BITS,
  parameter int IDX_W       = 4
) (
  input  logic                      clk,
  input  logic                      rst,
  input  ttab_pkg::ttab_store_ctl_t ctl,
  input  logic [IDX_W-1:0]          idx,
  input  logic                      wr_once,
  input  logic [31:0]               wr_period,
  input  logic [TIME_BITS-1:0]      wr_expiry,
  input  logic [7:0]                wr_event,
  output logic                      rd_valid,
  output logic                      rd_once,
  output logic [31:0]               rd_period,
  output logic [TIME_BITS-1:0]      rd_expiry,
  output logic [7:0]                rd_event
);
  import ttab_pkg::*;

  logic                 valid [TIMER_SLOTS];
  logic                 once_mem [TIMER_SLOTS];
  logic [31:0]          period_mem [TIMER_SLOTS];
  logic [TIME_BITS-1:0] expiry_mem [TIMER_SLOTS];
  logic [7:0]           event_mem [TIMER_SLOTS];

  always_ff @(posedge clk) begin
    if (rst || ctl.clr_all) begin
      for (int i = 0; i < TIMER_SLOTS; i++) begin
        valid[i] <= 1'b0;
      end
    end else if (ctl.set_valid) begin
      valid[idx] <= 1'b1;
    end else if (ctl.clr_valid) begin
      valid[idx] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= valid[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.wr_all) begin
      once_mem[idx]   <= wr_once;
      period_mem[idx] <= wr_period;
      event_mem[idx]  <= wr_event;
    end
    if (ctl.wr_all || ctl.wr_exp) begin
      expiry_mem[idx] <= wr_expiry;
    end
    rd_once   <= once_mem[idx];
    rd_period <= period_mem[idx];
    rd_expiry <= expiry_mem[idx];
    rd_event  <= event_mem[idx];
  end

endmodule

// ----- hdl/ttab_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timer catch-up divider
// Restoring divider, one quotient bit per cycle, giving quotient and remainder.
// ----------------------------------------------------------------------------
module ttab_div #(
  parameter int TIME_BITS = ttab_pkg::DEF_TIME_BITS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [TIME_BITS-1:0] dividend,
  input  logic [31:0]          divisor,
  output logic                 done,
  output logic [TIME_BITS-1:0] quo,
  output logic [31:0]          rem
);
  import ttab_pkg::*;

  localparam int CNT_W = $clog2(TIME_BITS + 1);

  logic                 busy;
  logic [CNT_W-1:0]     cnt;
  logic [TIME_BITS-1:0] dvd;
  logic [32:0]          trial;
  logic [32:0]          diff;
  logic                 fits;

  assign trial = {rem, dvd[TIME_BITS-1]};
  assign diff  = trial - {1'b0, divisor};
  assign fits  = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(TIME_BITS);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      rem <= '0;
      quo <= '0;
    end else if (busy) begin
      dvd <= dvd << 1;
      rem <= fits ? diff[31:0] : trial[31:0];
      quo <= {quo[TIME_BITS-2:0], fits};
    end
  end

endmodule

// ----- hdl/timer_table_engine.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timer table engine
// Table of one-shot and periodic timers walked slot by slot by a sequencer.
// ----------------------------------------------------------------------------
// Add, soonest and apply operations walk the slot table one slot at a time
// through a memory with a registered read; an add stops at the first free
// slot, while a clear and a rejected add walk no slots. Each expired
// periodic timer in an apply also runs the shared bit-serial divider for
// its catch-up count. Results leave one word at a time, and the block takes
// no new word until the last result of the current one has been taken.
module timer_table_engine #(
  parameter int TIMER_SLOTS = ttab_pkg::DEF_SLOTS,
  parameter int TIME_BITS   = ttab_pkg::DEF_TIME_BITS
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // now_ms[47:0], delay_ms[79:48], one_shot[80], event_id[88:81], zero fill
  input  logic [ttab_pkg::IN_DATA_W-1:0]     s_tdata,
  // operation[1:0]
  input  logic [ttab_pkg::OP_W-1:0]          s_tuser,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // status[1:0], slot[5:2], soonest_ms[37:6], fired_event[45:38],
  // fire_count[53:46], zero fill
  output logic [ttab_pkg::OUT_DATA_W-1:0]    m_tdata,
  // kind[2:0]
  output logic [ttab_pkg::KIND_W-1:0]        m_tuser,
  output logic                               m_tlast
);
  import ttab_pkg::*;

  localparam int IDX_W = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
  localparam int SUM_W = ((TIME_BITS > 32) ? TIME_BITS : 32) + 1;
  localparam logic [TIME_BITS-1:0] TIME_MASK = '1;

  ttab_state_t state, state_next, ret_state, ret_next;

  logic [IDX_W-1:0]     idx;
  ttab_op_t             op_q;
  logic [TIME_BITS-1:0] now_q;
  logic [31:0]          delay_q;
  logic                 once_q;
  logic [7:0]           evt_q;
  logic                 any_q;
  logic [TIME_BITS-1:0] best_q;
  logic [TIME_BITS-1:0] rem_q;
  logic [TIME_BITS-1:0] base_q;

  ttab_kind_t   res_kind;
  ttab_status_t res_status;
  logic [3:0]   res_slot;
  logic [31:0]  res_soon;
  logic [7:0]   res_evt;
  logic [7:0]   res_cnt;
  logic         res_last;

  // Input word fields.
  logic [47:0] in_now;
  logic [31:0] in_delay;
  logic        in_once;
  logic [7:0]  in_evt;
  ttab_op_t    in_op;
  logic [63:0] in_now_wide;
  logic        in_reject;

  assign in_now      = s_tdata[47:0];
  assign in_delay    = s_tdata[79:48];
  assign in_once     = s_tdata[80];
  assign in_evt      = s_tdata[88:81];
  assign in_op       = ttab_op_t'(s_tuser);
  assign in_now_wide = {16'd0, in_now};
  assign in_reject   = (in_op == OP_ADD) && !in_once && (in_delay == 32'd0);

  // Store and divider.
  ttab_store_ctl_t      st_ctl;
  logic                 rd_valid;
  logic                 rd_once;
  logic [31:0]          rd_period;
  logic [TIME_BITS-1:0] rd_expiry;
  logic [7:0]           rd_event;
  logic                 div_start;
  logic                 div_done;
  logic [TIME_BITS-1:0] div_quo;
  logic [31:0]          div_rem;

  // Shared datapath.
  logic [TIME_BITS:0]   cmp_diff;
  logic                 exp_le_now;
  logic [TIME_BITS-1:0] soon_rem;
  logic [TIME_BITS-1:0] age;
  logic [SUM_W-1:0]     add_a;
  logic [SUM_W-1:0]     add_b;
  logic [SUM_W-1:0]     add_sum;
  logic [TIME_BITS-1:0] new_exp;
  logic [SUM_W-1:0]     base_sum;
  logic [SUM_W-1:0]     best_ext;
  logic [31:0]          soon_ans;
  logic [7:0]           fire_cnt;
  logic                 last_idx;
  logic [8:0]           idx_wide;
  logic                 period_zero;

  assign cmp_diff    = {1'b0, rd_expiry} - {1'b0, now_q};
  assign exp_le_now  = cmp_diff[TIME_BITS] || (cmp_diff[TIME_BITS-1:0] == '0);
  assign soon_rem    = exp_le_now ? '0 : cmp_diff[TIME_BITS-1:0];
  assign age         = now_q - rd_expiry;
  assign period_zero = (rd_period == 32'd0);

  // One adder serves both the add expiry and the periodic advance.
  assign add_a   = (state == S_WB) ? SUM_W'(base_q) : SUM_W'(now_q);
  assign add_b   = (state == S_WB) ? SUM_W'(rd_period) : SUM_W'(delay_q);
  assign add_sum = add_a + add_b;
  assign new_exp = (add_sum > SUM_W'(TIME_MASK)) ? TIME_MASK : add_sum[TIME_BITS-1:0];

  // The advanced expiry is now minus the remainder plus one period.
  assign base_sum = SUM_W'(now_q) - SUM_W'(div_rem);

  assign best_ext = SUM_W'(best_q);
  assign soon_ans = !any_q ? SOON_EMPTY :
                    (best_ext > SUM_W'(SOON_MAX)) ? SOON_MAX : best_ext[31:0];
  assign fire_cnt = (div_quo >= TIME_BITS'(CNT_MAX)) ? CNT_MAX : div_quo[7:0] + 8'd1;
  assign last_idx = (idx == IDX_W'(TIMER_SLOTS - 1));
  assign idx_wide = 9'(idx);

  ttab_store #(
    .TIMER_SLOTS (TIMER_SLOTS),
    .TIME_BITS   (TIME_BITS),
    .IDX_W       (IDX_W)
  ) u_store (
    .clk       (clk),
    .rst       (rst),
    .ctl       (st_ctl),
    .idx       (idx),
    .wr_once   (once_q),
    .wr_period (delay_q),
    .wr_expiry (new_exp),
    .wr_event  (evt_q),
    .rd_valid  (rd_valid),
    .rd_once   (rd_once),
    .rd_period (rd_period),
    .rd_expiry (rd_expiry),
    .rd_event  (rd_event)
  );

  ttab_div #(
    .TIME_BITS (TIME_BITS)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (age),
    .divisor  (rd_period),
    .done     (div_done),
    .quo      (div_quo),
    .rem      (div_rem)
  );

  // Sequencer: next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          if (in_op == OP_CLEAR || in_reject) begin
            state_next = S_SEND;
          end else begin
            state_next = S_READ;
          end
        end
      end
      S_READ: state_next = S_CHECK;
      S_CHECK: begin
        unique case (op_q)
          OP_ADD:     state_next = rd_valid ? S_NEXT : S_SEND;
          OP_SOONEST: state_next = S_MIN;
          OP_APPLY: begin
            if (rd_valid && exp_le_now) begin
              state_next = (rd_once || period_zero) ? S_SEND : S_DIV;
            end else begin
              state_next = S_NEXT;
            end
          end
          OP_CLEAR:   state_next = S_IDLE;
        endcase
      end
      S_MIN:  state_next = S_NEXT;
      S_DIV:  state_next = div_done ? S_BASE : S_DIV;
      S_BASE: state_next = S_WB;
      S_WB:   state_next = S_SEND;
      S_NEXT: state_next = last_idx ? S_SEND : S_READ;
      S_SEND: state_next = m_tready ? ret_state : S_SEND;
      default: state_next = S_IDLE;
    endcase
  end

  // Sequencer: controls and the next result word.
  ttab_kind_t   res_kind_n;
  ttab_status_t res_status_n;
  logic [3:0]   res_slot_n;
  logic [31:0]  res_soon_n;
  logic [7:0]   res_evt_n;
  logic [7:0]   res_cnt_n;
  logic         res_last_n;
  logic         emit;
  logic         in_ld;
  logic         idx_inc;
  logic         rem_ld;
  logic         min_step;
  logic         base_ld;

  always_comb begin
    s_tready     = 1'b0;
    st_ctl       = '0;
    div_start    = 1'b0;
    emit         = 1'b0;
    in_ld        = 1'b0;
    idx_inc      = 1'b0;
    rem_ld       = 1'b0;
    min_step     = 1'b0;
    base_ld      = 1'b0;
    ret_next     = S_IDLE;
    res_kind_n   = KIND_ADD_ACK;
    res_status_n = STAT_OK;
    res_slot_n   = 4'd0;
    res_soon_n   = 32'd0;
    res_evt_n    = 8'd0;
    res_cnt_n    = 8'd0;
    res_last_n   = 1'b0;
    unique case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        in_ld    = s_tvalid;
        if (s_tvalid) begin
          if (in_op == OP_CLEAR) begin
            st_ctl.clr_all = 1'b1;
            emit           = 1'b1;
            res_kind_n     = KIND_CLEARED;
            res_last_n     = 1'b1;
          end else if (in_reject) begin
            emit         = 1'b1;
            res_status_n = STAT_ZERO_PERIOD;
            res_last_n   = 1'b1;
          end
        end
      end
      S_CHECK: begin
        rem_ld = 1'b1;
        if (op_q == OP_ADD && !rd_valid) begin
          st_ctl.wr_all    = 1'b1;
          st_ctl.set_valid = 1'b1;
          emit             = 1'b1;
          res_slot_n       = idx_wide[3:0];
          res_last_n       = 1'b1;
        end else if (op_q == OP_APPLY && rd_valid && exp_le_now) begin
          if (rd_once || period_zero) begin
            st_ctl.clr_valid = 1'b1;
            emit             = 1'b1;
            res_kind_n       = KIND_FIRING;
            res_slot_n       = idx_wide[3:0];
            res_evt_n        = rd_event;
            res_cnt_n        = 8'd1;
            ret_next         = S_NEXT;
          end else begin
            div_start = 1'b1;
          end
        end
      end
      S_MIN:  min_step = 1'b1;
      S_BASE: base_ld = 1'b1;
      S_WB: begin
        st_ctl.wr_exp = 1'b1;
        emit          = 1'b1;
        res_kind_n    = KIND_FIRING;
        res_slot_n    = idx_wide[3:0];
        res_evt_n     = rd_event;
        res_cnt_n     = fire_cnt;
        ret_next      = S_NEXT;
      end
      S_NEXT: begin
        if (last_idx) begin
          emit       = 1'b1;
          res_last_n = 1'b1;
          unique case (op_q)
            OP_ADD:     res_status_n = STAT_FULL;
            OP_SOONEST: begin
              res_kind_n = KIND_SOONEST;
              res_soon_n = soon_ans;
            end
            OP_APPLY:   res_kind_n = KIND_DONE;
            OP_CLEAR:   res_kind_n = KIND_CLEARED;
          endcase
        end else begin
          idx_inc = 1'b1;
        end
      end
      S_READ, S_DIV, S_SEND: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      ret_state <= S_IDLE;
      m_tvalid  <= 1'b0;
      idx       <= '0;
      any_q     <= 1'b0;
    end else begin
      state <= state_next;
      if (emit) begin
        ret_state <= ret_next;
        m_tvalid  <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (in_ld) begin
        idx   <= '0;
        any_q <= 1'b0;
      end else if (idx_inc) begin
        idx <= idx + 1'b1;
      end
      if (min_step && rd_valid) begin
        any_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ld) begin
      op_q    <= in_op;
      now_q   <= in_now_wide[TIME_BITS-1:0];
      delay_q <= in_delay;
      once_q  <= in_once;
      evt_q   <= in_evt;
    end
    if (rem_ld) begin
      rem_q <= soon_rem;
    end
    if (min_step && rd_valid && (!any_q || rem_q < best_q)) begin
      best_q <= rem_q;
    end
    if (base_ld) begin
      base_q <= base_sum[TIME_BITS-1:0];
    end
    if (emit) begin
      res_kind   <= res_kind_n;
      res_status <= res_status_n;
      res_slot   <= res_slot_n;
      res_soon   <= res_soon_n;
      res_evt    <= res_evt_n;
      res_cnt    <= res_cnt_n;
      res_last   <= res_last_n;
    end
  end

  assign m_tdata = {2'b00, res_cnt, res_evt, res_soon, res_slot, res_status};
  assign m_tuser = res_kind;
  assign m_tlast = res_last;

`ifndef SYNTH
  // A new word is only taken once the output register has drained.
  a_ready_empty: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> !m_tvalid)
    else $error("input accepted while a result word is pending");

  // The divider finishes only while the sequencer waits for it.
  a_div_in_wait: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == S_DIV)
    else $error("divider finished outside its wait state");

  // Taking the final word of an operation returns the block to idle.
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && m_tlast |=> state == S_IDLE)
    else $error("block not idle after the final result word");

  // A firing word always carries a nonzero count.
  a_fire_count: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (res_kind == KIND_FIRING) |-> res_cnt != 8'd0)
    else $error("firing word with zero count");
`endif

endmodule
